// File: design/psl_pkg.sv
// Shared types and codes for the positional shift list.
`default_nettype none

package psl_pkg;

  localparam int POS_W   = 5;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/psl_cell.sv
// One storage cell of the list row: holds an entry, loads it or takes a neighbour's.
`default_nettype none

module psl_cell #(
  parameter int WIDTH = 32,
  parameter int INDEX = 0
) (
  input  wire logic             clk,
  input  wire psl_pkg::cmd_t    cmd,
  input  wire logic [WIDTH-1:0] elem,
  input  wire logic [WIDTH-1:0] left,
  input  wire logic [WIDTH-1:0] right,
  output logic      [WIDTH-1:0] value
);

  localparam logic [31:0] IDX = 32'(INDEX);

  logic [31:0] pos_w;
  logic        above;
  logic        at;

  assign pos_w = 32'(cmd.pos);
  assign above = IDX > pos_w;
  assign at    = IDX == pos_w;

  always_ff @(posedge clk) begin
    if (cmd.ins && above) begin
      // shift up: take the entry below
      value <= left;
    end else if (cmd.ins && at) begin
      value <= elem;
    end else if (cmd.rem && (above || at)) begin
      // shift down: take the entry above
      value <= right;
    end
  end

endmodule

`default_nettype wire

// File: design/positional_shift_list_top.sv
// Top level of the positional shift list: count, request decode, cell row, result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------
//  request | in_valid  | in_stall  | kind, position, element_value
//  result  | out_valid | out_stall | status, read_value, entry_count_out
//
// One word a cycle while in_stall is low: an insert or remove shifts the cells at and above
// the position in the accepting cycle; the result is in the output register the next cycle.
// Reset clears the count and out_valid; entry contents and the result fields are not cleared.
// A result held by out_stall stalls the request side until it is taken.
`default_nettype none

module positional_shift_list_top #(
  parameter int DEPTH         = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   kind,
  input  wire logic [psl_pkg::POS_W-1:0]    position,
  input  wire logic [psl_pkg::DATA_W-1:0]   element_value,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [1:0]                   status,
  output logic      [psl_pkg::DATA_W-1:0]   read_value,
  output logic      [psl_pkg::COUNT_W-1:0]  entry_count_out
);

  localparam int EW    = ELEMENT_WIDTH;
  localparam int DW    = psl_pkg::DATA_W;
  localparam int OW    = psl_pkg::COUNT_W;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int CMP_W = (CW > psl_pkg::POS_W) ? CW : psl_pkg::POS_W;

  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic             accept;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] count_ext;
  logic             pos_lt;
  logic             pos_le;
  logic             full;
  logic [IW-1:0]    rd_idx;
  logic [1:0]       status_next;
  logic [DW-1:0]    read_next;
  logic             do_ins;
  logic             do_rem;
  logic [EW-1:0]    elem;
  logic [EW-1:0]    vals [DEPTH];
  psl_pkg::cmd_t    cmd;

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign pos_ext   = CMP_W'(position);
  assign count_ext = CMP_W'(count);
  assign pos_lt    = pos_ext < count_ext;
  assign pos_le    = pos_ext <= count_ext;
  assign full      = count == CW'(DEPTH);
  assign rd_idx    = pos_ext[IW-1:0];
  assign elem      = EW'(element_value);

  always_comb begin
    status_next = psl_pkg::ST_RANGE;
    read_next   = '0;
    count_next  = count;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    case (kind)
      psl_pkg::KIND_READ: begin
        if (pos_lt) begin
          status_next = psl_pkg::ST_DONE;
          read_next   = DW'(vals[rd_idx]);
        end
      end
      psl_pkg::KIND_INSERT: begin
        if (pos_le) begin
          if (full) begin
            status_next = psl_pkg::ST_FULL;
          end else begin
            status_next = psl_pkg::ST_DONE;
            count_next  = count + CW'(1);
            do_ins      = 1'b1;
          end
        end
      end
      psl_pkg::KIND_REMOVE: begin
        if (pos_lt) begin
          status_next = psl_pkg::ST_DONE;
          count_next  = count - CW'(1);
          do_rem      = 1'b1;
        end
      end
      default: begin
        status_next = psl_pkg::ST_RANGE;
      end
    endcase
  end

  assign cmd.ins = accept && do_ins;
  assign cmd.rem = accept && do_rem;
  assign cmd.pos = position;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [EW-1:0] left;
    logic [EW-1:0] right;
    if (i == 0) begin : g_first
      assign left = elem;
    end else begin : g_left
      assign left = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = vals[i];
    end else begin : g_right
      assign right = vals[i+1];
    end
    psl_cell #(
      .WIDTH (EW),
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .elem  (elem),
      .left  (left),
      .right (right),
      .value (vals[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count           <= count_next;
        out_valid       <= 1'b1;
        status          <= status_next;
        read_value      <= read_next;
        entry_count_out <= OW'(count_next);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count_out == OW'(count))
    else $error("reported count differs from held count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the list");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != psl_pkg::ST_DONE |-> read_value == '0)
    else $error("failed request returned a nonzero word");
`endif

endmodule

`default_nettype wire

// File: dv/tb_positional_shift_list_top.sv
// Self-checking testbench for the positional shift list: directed and random list operations.
`default_nettype none

module tb_positional_shift_list_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         DEPTH        = 16;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0]                  st;
    logic [psl_pkg::DATA_W-1:0]  word;
    logic [psl_pkg::COUNT_W-1:0] held_count;
  } list_result_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [1:0]                   kind;
  logic [psl_pkg::POS_W-1:0]    position;
  logic [psl_pkg::DATA_W-1:0]   element_value;
  logic                         out_valid;
  logic                         out_stall;
  logic [1:0]                   status;
  logic [psl_pkg::DATA_W-1:0]   read_value;
  logic [psl_pkg::COUNT_W-1:0]  entry_count_out;

  // Shadow copy of the list contents and count.
  logic [psl_pkg::DATA_W-1:0]   shadow_list [DEPTH];
  int                           held;
  list_result_t                 awaited_results[$];
  int                           mismatches = 0;

  int                           burst_left;
  int                           gap_max;
  int                           stall_pct;
  int                           hold_requests;

  positional_shift_list_top #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (psl_pkg::DATA_W)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .position        (position),
    .element_value   (element_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .read_value      (read_value),
    .entry_count_out (entry_count_out)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic list_result_t list_after_request(input logic [1:0] k,
                                                      input logic [psl_pkg::POS_W-1:0] p,
                                                      input logic [psl_pkg::DATA_W-1:0] v);
    list_result_t r;
    int i;
    r.st         = psl_pkg::ST_RANGE;
    r.word       = '0;
    r.held_count = '0;
    case (k)
      psl_pkg::KIND_READ: begin
        if (p < held) begin
          r.word = shadow_list[p];
          r.st   = psl_pkg::ST_DONE;
        end
      end
      psl_pkg::KIND_INSERT: begin
        // Range check takes priority over fullness.
        if (p <= held) begin
          if (held >= DEPTH) begin
            r.st = psl_pkg::ST_FULL;
          end else begin
            for (i = held; i > p; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[p] = v;
            held++;
            r.st = psl_pkg::ST_DONE;
          end
        end
      end
      psl_pkg::KIND_REMOVE: begin
        if (p < held) begin
          for (i = p; i + 1 < held; i++) shadow_list[i] = shadow_list[i+1];
          held--;
          r.st = psl_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
    r.held_count = held[psl_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // Call at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic [1:0] k, input logic [psl_pkg::POS_W-1:0] p,
                           input logic [psl_pkg::DATA_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      gap        = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    kind          <= k;
    position      <= p;
    element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(list_after_request(k, p, v));
    burst_left--;
  endtask

  task automatic send_random_word(input int ins_pct, input int rem_pct);
    int roll;
    logic [1:0] k;
    logic [psl_pkg::POS_W-1:0] p;
    roll = $urandom_range(99, 0);
    if (roll < ins_pct)                k = psl_pkg::KIND_INSERT;
    else if (roll < ins_pct + rem_pct) k = psl_pkg::KIND_REMOVE;
    else if (roll < 96)                k = psl_pkg::KIND_READ;
    else                               k = KIND_UNKNOWN;
    // Mostly legal positions, some noise across the whole field.
    if ($urandom_range(99, 0) < 15)     p = psl_pkg::POS_W'($urandom_range(31, 0));
    else if (k == psl_pkg::KIND_INSERT) p = psl_pkg::POS_W'($urandom_range(held, 0));
    else if (held > 0)                  p = psl_pkg::POS_W'($urandom_range(held - 1, 0));
    else                                p = '0;
    send_word(k, p, $urandom);
  endtask

  task automatic test_empty_and_edges();
    int i;
    send_word(psl_pkg::KIND_READ,   5'd0,  32'h1234_5678);
    send_word(psl_pkg::KIND_READ,   5'd31, 32'h0);
    send_word(psl_pkg::KIND_REMOVE, 5'd0,  32'h0);
    send_word(psl_pkg::KIND_INSERT, 5'd1,  32'hDEAD_BEEF);
    send_word(KIND_UNKNOWN,         5'd0,  32'hFFFF_FFFF);
    send_word(psl_pkg::KIND_INSERT, 5'd0,  32'h0000_0000);
    send_word(psl_pkg::KIND_INSERT, 5'd1,  32'hFFFF_FFFF);
    send_word(psl_pkg::KIND_INSERT, 5'd0,  32'hA5A5_A5A5);
    send_word(psl_pkg::KIND_INSERT, 5'd1,  32'h5A5A_5A5A);
    for (i = 0; i <= 4; i++) send_word(psl_pkg::KIND_READ, psl_pkg::POS_W'(i), 32'h0);
    send_word(psl_pkg::KIND_REMOVE, 5'd3,  32'h0);
    send_word(psl_pkg::KIND_REMOVE, 5'd0,  32'h0);
    send_word(psl_pkg::KIND_REMOVE, 5'd1,  32'h0);
    send_word(psl_pkg::KIND_REMOVE, 5'd1,  32'h0);
    send_word(psl_pkg::KIND_READ,   5'd0,  32'h0);
  endtask

  task automatic test_fill_and_empty();
    while (held < DEPTH)
      send_word(psl_pkg::KIND_INSERT, psl_pkg::POS_W'($urandom_range(held, 0)), $urandom);
    send_word(psl_pkg::KIND_INSERT, 5'd0,  32'h1111_1111);
    send_word(psl_pkg::KIND_INSERT, 5'd16, 32'h2222_2222);
    send_word(psl_pkg::KIND_INSERT, 5'd17, 32'h3333_3333);
    send_word(psl_pkg::KIND_INSERT, 5'd31, 32'h4444_4444);
    send_word(psl_pkg::KIND_READ,   5'd15, 32'h0);
    send_word(psl_pkg::KIND_READ,   5'd16, 32'h0);
    send_word(KIND_UNKNOWN,         5'd15, 32'h0);
    send_word(psl_pkg::KIND_REMOVE, 5'd15, 32'h0);
    send_word(psl_pkg::KIND_INSERT, 5'd15, 32'hFFFF_FFFF);
    send_word(psl_pkg::KIND_REMOVE, 5'd16, 32'h0);
    while (held > 0)
      send_word(psl_pkg::KIND_REMOVE, psl_pkg::POS_W'($urandom_range(held - 1, 0)), $urandom);
    send_word(psl_pkg::KIND_READ,   5'd0,  32'h0);
  endtask

  task automatic test_random_mix(input int n, input int ins_pct, input int rem_pct);
    repeat (n) send_random_word(ins_pct, rem_pct);
  endtask

  task automatic test_back_to_back();
    gap_max   = 0;
    stall_pct = 0;
    repeat (150) send_random_word(45, 40);
  endtask

  // Stall the result side for a long stretch while words keep coming.
  task automatic test_long_hold();
    gap_max       = 0;
    stall_pct     = 20;
    hold_requests <= hold_requests + 1;
    repeat (60) send_random_word(45, 40);
  endtask

  initial begin : receiver
    int run_left;
    int hold_left;
    int holds_served;
    logic run_stall;
    out_stall    = 1'b0;
    run_left     = 0;
    hold_left    = 0;
    holds_served = 0;
    run_stall    = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = 150;
        out_stall <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_left  = $urandom_range(12, 1);
          run_stall = ($urandom_range(99, 0) < stall_pct);
        end
        out_stall <= run_stall;
        run_left--;
      end
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with none pending: status %0d value %h count %0d",
                   $realtime, status, read_value, entry_count_out);
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.st || read_value !== want.word ||
            entry_count_out !== want.held_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: exp status %0d value %h count %0d, got status %0d value %h count %0d",
                     $realtime, want.st, want.word, want.held_count,
                     status, read_value, entry_count_out);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    kind          = psl_pkg::KIND_READ;
    position      = '0;
    element_value = '0;
    held          = 0;
    burst_left    = 0;
    gap_max       = 0;
    stall_pct     = 0;
    hold_requests = 0;
    for (int i = 0; i < DEPTH; i++) shadow_list[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    gap_max   = 3;
    stall_pct = 25;
    test_empty_and_edges();
    test_fill_and_empty();
    gap_max   = 4;
    stall_pct = 30;
    test_random_mix(250, 60, 20);
    gap_max   = 2;
    stall_pct = 50;
    test_random_mix(250, 40, 40);
    test_back_to_back();
    gap_max   = 6;
    stall_pct = 20;
    test_random_mix(250, 20, 60);
    test_long_hold();

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
design/psl_pkg.sv
design/psl_cell.sv
design/positional_shift_list_top.sv
dv/tb_positional_shift_list_top.sv
